[rtl/swt_pkg.sv]
// Shared types and character codes for the shell word tokenizer.
// No dependencies; compile first.
package swt_pkg;

  // Characters with a quoting or separating role
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Results one input transfer can cause
  localparam int unsigned MaxResults = 3;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PLAIN = 2'd1,
    ESC_DQ    = 2'd2
  } esc_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       kind;
    logic       line_done;
    logic       run_last;
  } result_t;

endpackage

[rtl/swt_if.sv]
// Valid/ready channel interfaces for the shell word tokenizer.
// Input channel carries one line byte, output channel one result.
// Standalone; no package dependency.
interface swt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       has_byte;
  logic       line_end;

  modport source (output valid, output in_byte, output has_byte, output line_end,
                  input ready);
  modport sink   (input valid, input in_byte, input has_byte, input line_end,
                  output ready);
endinterface

interface swt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       kind;
  logic       line_done;
  logic       run_last;

  modport source (output valid, output out_byte, output kind, output line_done,
                  output run_last, input ready);
  modport sink   (input valid, input out_byte, input kind, input line_done,
                  input run_last, output ready);
endinterface

[rtl/shell_word_tokenizer.sv]
// Shell word tokenizer: first result is valid the cycle after its input transfer.
// Throughput: one input transfer per cycle while each item yields at most one
// result and the output is ready; an item with k results (k up to 3) holds the
// bank until all k leave, as it drains one result per cycle while ready is high.
// Reset (rst_ni low, asynchronous) clears quote/escape state and the result bank.
module shell_word_tokenizer
  import swt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  swt_in_if.sink   in_i,
  swt_out_if.source out_o
);

  // Tokenizer state: quoting mode, open word, pending backslash
  logic single_q, single_d;
  logic double_q, double_d;
  logic open_q,   open_d;
  esc_e esc_q,    esc_d;

  // Result bank: head entry at index 0 drives the output channel
  result_t    res_q [MaxResults];
  result_t    res_d [MaxResults];
  result_t    calc  [MaxResults];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] calc_n;

  logic in_fire, out_fire;
  logic dq_special;

  assign out_fire = out_o.valid && out_o.ready;
  // Take a new item when the bank is empty or its last result leaves now
  assign in_i.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;

  assign dq_special = (in_i.in_byte == CH_DQUOTE) || (in_i.in_byte == CH_BSLASH) ||
                      (in_i.in_byte == CH_DOLLAR) || (in_i.in_byte == CH_BTICK);

  // Per-item work: next state and up to three results, in emission order
  always_comb begin
    single_d = single_q;
    double_d = double_q;
    open_d   = open_q;
    esc_d    = esc_q;
    calc_n   = 2'd0;
    for (int i = 0; i < MaxResults; i++) begin
      calc[i] = '0;
    end

    if (in_i.has_byte) begin
      case (esc_q)
        ESC_PLAIN: begin
          // unquoted escape: byte taken literally
          esc_d                = ESC_NONE;
          calc[calc_n].out_byte = in_i.in_byte;
          calc_n               = calc_n + 2'd1;
          open_d               = 1'b1;
        end
        ESC_DQ: begin
          // inside double quotes the backslash survives unless the byte is special
          esc_d = ESC_NONE;
          if (!dq_special) begin
            calc[calc_n].out_byte = CH_BSLASH;
            calc_n               = calc_n + 2'd1;
          end
          calc[calc_n].out_byte = in_i.in_byte;
          calc_n               = calc_n + 2'd1;
          open_d               = 1'b1;
        end
        default: begin
          esc_d = ESC_NONE;
          if (in_i.in_byte == CH_BSLASH) begin
            if (single_q) begin
              calc[calc_n].out_byte = in_i.in_byte;
              calc_n               = calc_n + 2'd1;
              open_d               = 1'b1;
            end else if (double_q) begin
              esc_d = ESC_DQ;
            end else begin
              esc_d = ESC_PLAIN;
            end
          end else if ((in_i.in_byte == CH_DQUOTE) && !single_q) begin
            double_d = !double_q;
            open_d   = 1'b1;
          end else if ((in_i.in_byte == CH_SQUOTE) && !double_q) begin
            single_d = !single_q;
            open_d   = 1'b1;
          end else if (((in_i.in_byte == CH_SPACE) || (in_i.in_byte == CH_TAB)) &&
                       !single_q && !double_q) begin
            // unquoted blank closes an open word
            if (open_q) begin
              calc[calc_n].kind = KIND_END;
              calc_n           = calc_n + 2'd1;
              open_d           = 1'b0;
            end
          end else begin
            calc[calc_n].out_byte = in_i.in_byte;
            calc_n               = calc_n + 2'd1;
            open_d               = 1'b1;
          end
        end
      endcase
    end

    if (in_i.line_end) begin
      // flush the open word, drop any dangling backslash, reset quoting
      if (open_d) begin
        calc[calc_n].kind = KIND_END;
        calc_n           = calc_n + 2'd1;
      end
      single_d = 1'b0;
      double_d = 1'b0;
      open_d   = 1'b0;
      esc_d    = ESC_NONE;
      if (calc_n != 2'd0) begin
        calc[calc_n - 2'd1].line_done = 1'b1;
      end
    end

    if (calc_n != 2'd0) begin
      calc[calc_n - 2'd1].run_last = 1'b1;
    end
  end

  // Bank update: load on input transfer, shift toward the head on output transfer
  always_comb begin
    cnt_d = cnt_q;
    res_d = res_q;
    if (in_fire) begin
      cnt_d = calc_n;
      res_d = calc;
    end else if (out_fire) begin
      cnt_d = cnt_q - 2'd1;
      for (int i = 0; i < MaxResults - 1; i++) begin
        res_d[i] = res_q[i + 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_q <= 1'b0;
      double_q <= 1'b0;
      open_q   <= 1'b0;
      esc_q    <= ESC_NONE;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        single_q <= single_d;
        double_q <= double_d;
        open_q   <= open_d;
        esc_q    <= esc_d;
      end
    end
  end

  // Payload bank, no reset needed
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid     = (cnt_q != 2'd0);
  assign out_o.out_byte  = res_q[0].out_byte;
  assign out_o.kind      = res_q[0].kind;
  assign out_o.line_done = res_q[0].line_done;
  assign out_o.run_last  = res_q[0].run_last;

  // Line end leaves no quoting, escape or open word behind
  a_line_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.line_end |=> !single_q && !double_q && !open_q && (esc_q == ESC_NONE))
    else $error("state not cleared after line end");

  // The last result in the bank is the last one of its item
  a_last_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (cnt_q == 2'd1) |-> out_o.run_last)
    else $error("final queued result lacks run_last");

  // A result that is not its item's last is followed by another
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !out_o.run_last |=> out_o.valid)
    else $error("item results cut short");

  // An end-of-word result carries a zero byte
  a_end_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind == KIND_END) |-> (out_o.out_byte == 8'h00))
    else $error("word end with nonzero byte");

endmodule

[tb/shell_word_tokenizer_test.sv]
// Self-checking testbench for shell_word_tokenizer: directed table plus random command lines.
// Depends on swt_pkg (rtl/swt_pkg.sv) and the channel interfaces in rtl/swt_if.sv.
// A local tokenizer model predicts the results of untyped rows; the run ends with one verdict line.
module shell_word_tokenizer_test
  import swt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 2;
  localparam int RESET_CYCLES = 4;
  localparam int RUN_LIMIT = 200000;   // cycles; far beyond the slowest legal run
  localparam int PHASE_ITEMS = 90;     // counted items per idling phase
  localparam int SQUEEZE_ITEMS = 24;   // items offered from the start of the output hold-off
  localparam int HOLD_CYCLES = 60;     // length of that hold-off
  localparam int TAIL_CYCLES = 8;      // quiet cycles after the last expected result
  localparam int PREDICT = -1;         // table row checked against the model

  // Idling per phase: none, sender only, receiver only, both lightly
  localparam int SEND_IDLE [4] = '{0, 72, 0, 10};
  localparam int RECV_STALL [4] = '{0, 0, 72, 10};

  typedef result_t result_q_t [$];

  // One stimulus row; lit_n >= 0 means the expected results are typed in lit_res
  typedef struct {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       line_end;
    int         lit_n;
    result_t    lit_res [MaxResults];
  } stim_row_t;

  localparam result_t NO_LIT [MaxResults] = '{default: '0};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic rx_ready = 1'b0;
  logic hold_off = 1'b0;
  int   stall_pct = 0;
  int   send_idle_pct = 0;
  int   items_sent = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;

  // Tokenizer model state
  logic in_sq;
  logic in_dq;
  logic word_live;
  esc_e esc_state;

  result_t pending_results [$];

  swt_in_if  in_ch ();
  swt_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  shell_word_tokenizer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Directed rows. The quoting state carries from row to row, so the order matters.
  stim_row_t directed_rows [30] = '{
    // plain letter straight out of reset
    '{8'h41, 1'b1, 1'b0, 1, '{'{8'h41, KIND_CHAR, 1'b0, 1'b1}, '0, '0}},
    // tab closes the word
    '{CH_TAB, 1'b1, 1'b0, 1, '{'{8'h00, KIND_END, 1'b0, 1'b1}, '0, '0}},
    // top byte value, line end flushes the word it opened
    '{8'hFF, 1'b1, 1'b1, 2, '{'{8'hFF, KIND_CHAR, 1'b0, 1'b0},
                              '{8'h00, KIND_END, 1'b1, 1'b1}, '0}},
    // blank line: nothing at all comes out
    '{8'h00, 1'b0, 1'b1, 0, NO_LIT},
    // bare item without line end is a no-op
    '{8'hFF, 1'b0, 1'b0, 0, NO_LIT},
    // single quotes: backslash is literal
    '{CH_SQUOTE, 1'b1, 1'b0, PREDICT, NO_LIT},
    '{CH_BSLASH, 1'b1, 1'b0, PREDICT, NO_LIT},
    '{CH_SQUOTE, 1'b1, 1'b0, PREDICT, NO_LIT},
    '{CH_SPACE,  1'b1, 1'b0, PREDICT, NO_LIT},
    // double quotes: backslash kept before an ordinary byte
    '{CH_DQUOTE, 1'b1, 1'b0, PREDICT, NO_LIT},
    '{CH_BSLASH, 1'b1, 1'b0, PREDICT, NO_LIT},
    '{8'h61,     1'b1, 1'b0, PREDICT, NO_LIT},
    // ... and dropped before the four escapable ones
    '{CH_BSLASH, 1'b1, 1'b0, PREDICT, NO_LIT},
    '{CH_DQUOTE, 1'b1, 1'b0, PREDICT, NO_LIT},
    '{CH_BSLASH, 1'b1, 1'b0, PREDICT, NO_LIT},
    '{CH_BSLASH, 1'b1, 1'b0, PREDICT, NO_LIT},
    '{CH_BSLASH, 1'b1, 1'b0, PREDICT, NO_LIT},
    '{CH_DOLLAR, 1'b1, 1'b0, PREDICT, NO_LIT},
    '{CH_BSLASH, 1'b1, 1'b0, PREDICT, NO_LIT},
    '{CH_BTICK,  1'b1, 1'b0, PREDICT, NO_LIT},
    // kept backslash + byte + word end in one item; quote still open at line end
    '{CH_BSLASH, 1'b1, 1'b0, PREDICT, NO_LIT},
    '{8'h7A,     1'b1, 1'b1, PREDICT, NO_LIT},
    // empty quotes still make a word
    '{CH_DQUOTE, 1'b1, 1'b0, PREDICT, NO_LIT},
    '{CH_DQUOTE, 1'b1, 1'b0, PREDICT, NO_LIT},
    '{CH_SPACE,  1'b1, 1'b0, PREDICT, NO_LIT},
    // unquoted backslash escapes a space into the word
    '{CH_BSLASH, 1'b1, 1'b0, PREDICT, NO_LIT},
    '{CH_SPACE,  1'b1, 1'b0, PREDICT, NO_LIT},
    // dangling backslash at line end with a word open
    '{CH_BSLASH, 1'b1, 1'b1, PREDICT, NO_LIT},
    // dangling backslash alone: no word, no result
    '{CH_BSLASH, 1'b1, 1'b0, PREDICT, NO_LIT},
    '{8'h00,     1'b0, 1'b1, 0, NO_LIT}
  };

  // Tokenizer model: consumes one input item, returns the results it causes.
  function automatic result_q_t tokenize_step(input logic [7:0] c, input logic has,
                                              input logic le);
    result_q_t batch;
    if (has) begin
      if (esc_state == ESC_PLAIN) begin
        esc_state = ESC_NONE;
        batch.insert(batch.size(), result_t'{c, KIND_CHAR, 1'b0, 1'b0});
        word_live = 1'b1;
      end else if (esc_state == ESC_DQ) begin
        esc_state = ESC_NONE;
        if (!(c inside {CH_DQUOTE, CH_BSLASH, CH_DOLLAR, CH_BTICK}))
          batch.insert(batch.size(), result_t'{CH_BSLASH, KIND_CHAR, 1'b0, 1'b0});
        batch.insert(batch.size(), result_t'{c, KIND_CHAR, 1'b0, 1'b0});
        word_live = 1'b1;
      end else if (c == CH_BSLASH) begin
        if (in_sq) begin
          batch.insert(batch.size(), result_t'{c, KIND_CHAR, 1'b0, 1'b0});
          word_live = 1'b1;
        end else if (in_dq) begin
          esc_state = ESC_DQ;
        end else begin
          esc_state = ESC_PLAIN;
        end
      end else if (c == CH_DQUOTE && !in_sq) begin
        in_dq = ~in_dq;
        word_live = 1'b1;
      end else if (c == CH_SQUOTE && !in_dq) begin
        in_sq = ~in_sq;
        word_live = 1'b1;
      end else if ((c == CH_SPACE || c == CH_TAB) && !in_sq && !in_dq) begin
        if (word_live) begin
          batch.insert(batch.size(), result_t'{8'h00, KIND_END, 1'b0, 1'b0});
          word_live = 1'b0;
        end
      end else begin
        batch.insert(batch.size(), result_t'{c, KIND_CHAR, 1'b0, 1'b0});
        word_live = 1'b1;
      end
    end
    if (le) begin
      if (word_live)
        batch.insert(batch.size(), result_t'{8'h00, KIND_END, 1'b0, 1'b0});
      in_sq = 1'b0;
      in_dq = 1'b0;
      word_live = 1'b0;
      esc_state = ESC_NONE;
      if (batch.size() > 0)
        batch[batch.size() - 1].line_done = 1'b1;
    end
    if (batch.size() > 0)
      batch[batch.size() - 1].run_last = 1'b1;
    return batch;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Offer one item, hold it until the transfer, then record what it must produce.
  task automatic send_item(input stim_row_t row);
    result_q_t batch;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_byte  <= row.in_byte;
    in_ch.has_byte <= row.has_byte;
    in_ch.line_end <= row.line_end;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    // Transfer happened at this edge; model always advances, typed rows override it
    batch = tokenize_step(row.in_byte, row.has_byte, row.line_end);
    if (row.lit_n == PREDICT) begin
      foreach (batch[i]) pending_results.insert(pending_results.size(), batch[i]);
    end else begin
      for (int i = 0; i < row.lit_n; i++)
        pending_results.insert(pending_results.size(), row.lit_res[i]);
    end
  endtask

  // Weighted toward the characters that drive the quoting rules
  function automatic logic [7:0] pick_line_char();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return 8'($urandom_range(8'h7A, 8'h61));
    if (roll < 52) return CH_SPACE;
    if (roll < 57) return CH_TAB;
    if (roll < 67) return CH_SQUOTE;
    if (roll < 77) return CH_DQUOTE;
    if (roll < 89) return CH_BSLASH;
    if (roll < 93) return CH_DOLLAR;
    if (roll < 96) return CH_BTICK;
    return 8'($urandom_range(255));
  endfunction

  // One command line of random content; now and then a blank line or a stray no-op item
  task automatic send_random_line();
    int unsigned len;
    stim_row_t row;
    row = '{8'h00, 1'b0, 1'b1, PREDICT, NO_LIT};
    if ($urandom_range(99) < 5) begin
      row.in_byte = 8'($urandom_range(255));
      send_item(row);
      items_sent++;
      return;
    end
    len = $urandom_range(12, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 5) begin
        row.in_byte = 8'($urandom_range(255));
        row.has_byte = 1'b0;
        row.line_end = 1'b0;
        send_item(row);   // ignored by the block; not counted
      end
      row.in_byte = pick_line_char();
      row.has_byte = 1'b1;
      row.line_end = (i == len - 1) && ($urandom_range(1) == 1);
      send_item(row);
      items_sent++;
    end
    if (!row.line_end) begin
      row.in_byte = 8'($urandom_range(255));
      row.has_byte = 1'b0;
      row.line_end = 1'b1;
      send_item(row);
      items_sent++;
    end
  endtask

  // Result side: check each transfer against the oldest expectation, then pick ready.
  always @(posedge clk_i or negedge rst_ni) begin : drain_results
    result_t want;
    if (!rst_ni) begin
      rx_ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", {out_ch.out_byte, out_ch.kind}, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_ch.out_byte, want.out_byte);
          if (out_ch.kind !== want.kind)
            report_mismatch("kind", out_ch.kind, want.kind);
          if (out_ch.line_done !== want.line_done)
            report_mismatch("line_done", out_ch.line_done, want.line_done);
          if (out_ch.run_last !== want.run_last)
            report_mismatch("run_last", out_ch.run_last, want.run_last);
        end
      end
      rx_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int target;
    in_sq = 1'b0;
    in_dq = 1'b0;
    word_live = 1'b0;
    esc_state = ESC_NONE;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.has_byte = 1'b0;
    in_ch.line_end = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, no idling
    foreach (directed_rows[i]) send_item(directed_rows[i]);

    // Random lines under each idling pattern
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = SEND_IDLE[p];
      stall_pct <= RECV_STALL[p];
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_random_line();

      // After the unthrottled phase: hold the output off long enough to back up the input
      if (p == 0) begin
        target = items_sent + SQUEEZE_ITEMS;
        fork
          begin
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk_i);
            hold_off <= 1'b0;
          end
          while (items_sent < target) send_random_line();
        join
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
rtl/swt_pkg.sv
rtl/swt_if.sv
rtl/shell_word_tokenizer.sv
tb/shell_word_tokenizer_test.sv
